// File: sv/bba_pkg.sv
`timescale 1ns / 1ps
package bba_pkg;

    localparam int WORD_BITS = 32;
    localparam int WORD_LSB  = 5;
    localparam int CHUNK     = 8;

    typedef enum logic [1:0] {
        MODE_ALLOC = 2'd0,
        MODE_FREE  = 2'd1,
        MODE_INIT  = 2'd2,
        MODE_RSVD  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_RANGE    = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CFG_BASE   = 2'd0,
        CFG_REGION = 2'd1,
        CFG_BLOCK  = 2'd2,
        CFG_WORDS  = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        DIV_SIZE   = 1'b0,
        DIV_OFFSET = 1'b1
    } t_div_sel;

    typedef enum logic [2:0] {
        WR_NONE = 3'd0,
        WR_ZERO = 3'd1,
        WR_MASK = 3'd2,
        WR_SET  = 3'd3,
        WR_CLR  = 3'd4
    } t_wr;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_DIV_A,
        S_DIV_F1,
        S_DIV_F2,
        S_DIV_I,
        S_FETCH,
        S_SCAN,
        S_MUL,
        S_MARK_BEGIN,
        S_MARK_RD,
        S_MARK_WR,
        S_SWEEP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic     accept;
        logic     div_start;
        t_div_sel div_sel;
        logic     start_from_q;
        logic     start_zero;
        logic     end_from_q;
        logic     widx_clear;
        logic     widx_inc;
        logic     widx_mark;
        logic     fetch;
        logic     scan;
        logic     mul;
        t_wr      wr;
        logic     out_load;
        t_status  out_status;
        logic     out_use_addr;
    } t_cmd;

    typedef struct packed {
        t_mode mode;
        logic  size_zero;
        logic  free_ok;
        logic  init_ok;
        logic  div_busy;
        logic  need_too_big;
        logic  scan_end;
        logic  found;
        logic  chunk_last;
        logic  mark_empty;
        logic  mark_last;
        logic  sweep_last;
    } t_stat;

endpackage

// File: sv/bba_div.sv
`timescale 1ns / 1ps
module bba_div import bba_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [15:0] i_den,
    output logic        o_busy,
    output logic [32:0] o_q
);
    // ceil(num / den) by restoring division of num-1, one bit a cycle
    logic        r_busy;
    logic [4:0]  r_cnt;
    logic [31:0] r_n;
    logic [15:0] r_rem;
    logic [15:0] r_den;
    logic [31:0] r_quot;
    logic        r_zero;
    logic [16:0] trial;
    logic        qbit;
    logic [16:0] diff;

    always_comb begin
        trial = {r_rem, r_n[31]};
        diff  = trial - {1'b0, r_den};
        qbit  = (trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 5'd1;
            if (r_cnt == 5'd31) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n    <= i_num - 32'd1;
            r_zero <= (i_num == 32'd0);
            r_rem  <= '0;
            r_den  <= (i_den == 16'd0) ? 16'd1 : i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_n    <= {r_n[30:0], 1'b0};
            r_rem  <= qbit ? diff[15:0] : trial[15:0];
            r_quot <= {r_quot[30:0], qbit};
        end
    end

    assign o_busy = r_busy;
    assign o_q    = r_zero ? 33'd0 : ({1'b0, r_quot} + 33'd1);
endmodule

// File: sv/bba_dp.sv
`timescale 1ns / 1ps
module bba_dp import bba_pkg::*; #(
    parameter int MAP_DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  logic [1:0]  i_mode,
    input  logic [31:0] i_size_bytes,
    input  logic [31:0] i_address,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output logic [1:0]  o_status,
    output logic [31:0] o_alloc_address
);
    localparam int LWW = $clog2(MAP_DEPTH + 1);
    localparam int WIW = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    localparam int BW  = LWW + WORD_LSB;
    localparam int CW  = (LWW > 6) ? LWW : 6;

    logic [31:0] r_base;
    logic [31:0] r_region;
    logic [15:0] r_block;
    logic [5:0]  r_map_words;

    t_mode       r_mode;
    logic [31:0] r_size;
    logic [31:0] r_addr_in;

    logic [WORD_BITS-1:0] r_map [MAP_DEPTH];
    logic [WORD_BITS-1:0] r_word;
    logic [LWW-1:0]       r_widx;
    logic [1:0]           r_chunk;
    logic [BW-1:0]        r_run;
    logic [BW-1:0]        r_start;
    logic [BW-1:0]        r_end;
    logic [31:0]          r_result;
    logic [1:0]           r_out_status;
    logic [31:0]          r_out_addr;

    logic [LWW-1:0]       lim_words;
    logic [BW-1:0]        lim;
    logic [32:0]          q;
    logic                 div_busy;
    logic [31:0]          div_num;
    logic [15:0]          eb;
    logic [BW-1:0]        run_v;
    logic                 fnd;
    logic [BW-1:0]        pos;
    logic [WORD_BITS-1:0] mask;
    logic [BW-1:0]        idx;
    logic [BW-1:0]        end_m1;
    logic [33:0]          sum;
    logic [BW+15:0]       prod;
    logic [WORD_BITS-1:0] wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= 32'd0;
            r_region    <= 32'd32768;
            r_block     <= 16'd32;
            r_map_words <= 6'd32;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_BASE:   r_base      <= i_cfg_data;
                CFG_REGION: r_region    <= i_cfg_data;
                CFG_BLOCK:  r_block     <= i_cfg_data[15:0];
                CFG_WORDS:  r_map_words <= i_cfg_data[5:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mode    <= t_mode'(i_mode);
            r_size    <= i_size_bytes;
            r_addr_in <= i_address;
        end
    end

    always_comb begin
        if (CW'(r_map_words) > CW'(MAP_DEPTH)) begin
            lim_words = LWW'(MAP_DEPTH);
        end else begin
            lim_words = LWW'(r_map_words);
        end
        lim = {lim_words, {WORD_LSB{1'b0}}};
    end

    assign eb      = (r_block == 16'd0) ? 16'd1 : r_block;
    assign div_num = (i_cmd.div_sel == DIV_OFFSET) ? (r_addr_in - r_base) : r_size;

    bba_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (r_block),
        .o_busy  (div_busy),
        .o_q     (q)
    );

    // scan one byte of the fetched word for the run end
    always_comb begin
        run_v = r_run;
        fnd   = 1'b0;
        pos   = '0;
        for (int k = 0; k < CHUNK; k++) begin
            if (r_word[{r_chunk, 3'(k)}]) begin
                run_v = '0;
            end else begin
                run_v = run_v + BW'(1);
                if (!fnd && run_v == q[BW-1:0]) begin
                    fnd = 1'b1;
                    pos = {r_widx[LWW-1:0], r_chunk, 3'(k)};
                end
            end
        end
    end

    always_comb begin
        for (int j = 0; j < WORD_BITS; j++) begin
            idx     = {r_widx, 5'(j)};
            mask[j] = (idx >= r_start) && (idx < r_end);
        end
        end_m1 = r_end - BW'(1);
        sum    = 34'(r_start) + 34'(q);
        prod   = r_start * eb;
    end

    always_comb begin
        unique case (i_cmd.wr)
            WR_ZERO: wdata = '0;
            WR_MASK: wdata = mask;
            WR_SET:  wdata = r_word | mask;
            WR_CLR:  wdata = r_word & ~mask;
            default: wdata = r_word;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr != WR_NONE) begin
            r_map[r_widx[WIW-1:0]] <= wdata;
        end
        r_word <= r_map[r_widx[WIW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_widx <= '0;
        end else if (i_cmd.widx_clear) begin
            r_widx <= '0;
        end else if (i_cmd.widx_mark) begin
            r_widx <= r_start[BW-1:WORD_LSB];
        end else if (i_cmd.widx_inc) begin
            r_widx <= r_widx + LWW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.widx_clear) begin
            r_run <= '0;
        end else if (i_cmd.scan) begin
            r_run <= run_v;
        end
        if (i_cmd.fetch) begin
            r_chunk <= '0;
        end else if (i_cmd.scan) begin
            r_chunk <= r_chunk + 2'd1;
        end
        if (i_cmd.start_zero) begin
            r_start <= '0;
        end else if (i_cmd.start_from_q) begin
            r_start <= (q > 33'(lim)) ? lim : q[BW-1:0];
        end else if (i_cmd.scan && fnd) begin
            r_start <= pos + BW'(1) - q[BW-1:0];
        end
        if (i_cmd.end_from_q) begin
            r_end <= (sum > 34'(lim)) ? lim : sum[BW-1:0];
        end
        if (i_cmd.mul) begin
            r_result <= r_base + 32'(prod);
        end
        if (i_cmd.out_load) begin
            r_out_status <= i_cmd.out_status;
            r_out_addr   <= i_cmd.out_use_addr ? r_result : 32'd0;
        end
    end

    always_comb begin
        o_stat.mode         = r_mode;
        o_stat.size_zero    = (r_size == 32'd0);
        o_stat.free_ok      = (r_addr_in >= r_base) &&
                              ({1'b0, r_addr_in} < ({1'b0, r_base} + {1'b0, r_region}));
        o_stat.init_ok      = (r_region != 32'd0) && (r_size <= r_region);
        o_stat.div_busy     = div_busy;
        o_stat.need_too_big = (q > 33'(lim));
        o_stat.scan_end     = (r_widx == lim_words);
        o_stat.found        = fnd;
        o_stat.chunk_last   = (r_chunk == 2'd3);
        o_stat.mark_empty   = (r_end <= r_start);
        o_stat.mark_last    = (r_widx == end_m1[BW-1:WORD_LSB]);
        o_stat.sweep_last   = (r_widx == LWW'(MAP_DEPTH - 1));
    end

    assign o_status        = r_out_status;
    assign o_alloc_address = r_out_addr;
endmodule

// File: sv/bba_ctrl.sv
`timescale 1ns / 1ps
module bba_ctrl import bba_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    output logic  o_out_valid,
    input  logic  i_out_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);
    t_state  r_state, n_state;
    t_status r_res, n_res;
    logic    r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_res       <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res       <= n_res;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_res       = r_res;
        o_cmd       = '0;
        o_cmd.wr    = WR_NONE;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.wr = WR_ZERO;
                o_cmd.widx_inc = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_res   = ST_RANGE;
                n_state = S_DONE;
                unique case (i_stat.mode)
                    MODE_ALLOC: begin
                        if (i_stat.size_zero) begin
                            n_res = ST_NO_SPACE;
                        end else begin
                            o_cmd.div_start = 1'b1;
                            o_cmd.div_sel = DIV_SIZE;
                            n_state = S_DIV_A;
                        end
                    end
                    MODE_FREE: begin
                        if (i_stat.free_ok) begin
                            o_cmd.div_start = 1'b1;
                            o_cmd.div_sel = DIV_OFFSET;
                            n_state = S_DIV_F1;
                        end
                    end
                    MODE_INIT: begin
                        if (i_stat.init_ok) begin
                            o_cmd.div_start = 1'b1;
                            o_cmd.div_sel = DIV_SIZE;
                            o_cmd.start_zero = 1'b1;
                            n_state = S_DIV_I;
                        end
                    end
                    default: ;
                endcase
            end
            S_DIV_A: begin
                if (!i_stat.div_busy) begin
                    if (i_stat.need_too_big) begin
                        n_res = ST_NO_SPACE;
                        n_state = S_DONE;
                    end else begin
                        o_cmd.widx_clear = 1'b1;
                        n_state = S_FETCH;
                    end
                end
            end
            S_DIV_F1: begin
                if (!i_stat.div_busy) begin
                    o_cmd.start_from_q = 1'b1;
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel = DIV_SIZE;
                    n_state = S_DIV_F2;
                end
            end
            S_DIV_F2: begin
                if (!i_stat.div_busy) begin
                    o_cmd.end_from_q = 1'b1;
                    n_res = ST_OK;
                    n_state = S_MARK_BEGIN;
                end
            end
            S_DIV_I: begin
                if (!i_stat.div_busy) begin
                    o_cmd.end_from_q = 1'b1;
                    o_cmd.widx_clear = 1'b1;
                    n_res = ST_OK;
                    n_state = S_SWEEP;
                end
            end
            S_FETCH: begin
                o_cmd.fetch = 1'b1;
                if (i_stat.scan_end) begin
                    n_res = ST_NO_SPACE;
                    n_state = S_DONE;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.found) begin
                    n_state = S_MUL;
                end else if (i_stat.chunk_last) begin
                    o_cmd.widx_inc = 1'b1;
                    n_state = S_FETCH;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                o_cmd.end_from_q = 1'b1;
                n_res = ST_OK;
                n_state = S_MARK_BEGIN;
            end
            S_MARK_BEGIN: begin
                o_cmd.widx_mark = 1'b1;
                n_state = i_stat.mark_empty ? S_DONE : S_MARK_RD;
            end
            S_MARK_RD: begin
                n_state = S_MARK_WR;
            end
            S_MARK_WR: begin
                o_cmd.wr = (i_stat.mode == MODE_ALLOC) ? WR_SET : WR_CLR;
                if (i_stat.mark_last) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.widx_inc = 1'b1;
                    n_state = S_MARK_RD;
                end
            end
            S_SWEEP: begin
                o_cmd.wr = WR_MASK;
                o_cmd.widx_inc = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_status = r_res;
                    o_cmd.out_use_addr = (r_res == ST_OK) && (i_stat.mode == MODE_ALLOC);
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
endmodule

// File: sv/bitmap_block_allocator_core.sv
`timescale 1ns / 1ps
// channel  | handshake                    | payload
// request  | i_in_valid / o_in_stall      | i_mode, i_size_bytes, i_address
// result   | o_out_valid / i_out_stall    | o_status, o_alloc_address
// config   | i_cfg_we                     | i_cfg_index, i_cfg_data
//
// One request at a time. Block counts come from a shared divider.
// Allocate: divide, scan map words for a free run, mark its words.
// Free: divide offset and size, clear words; init: divide, sweep all words.
// After reset a clearing pass over all map words runs with o_in_stall high.
// A waiting result does not block the next request from being taken.
module bitmap_block_allocator_core import bba_pkg::*; #(
    parameter int MAP_DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_mode,
    input  logic [31:0] i_size_bytes,
    input  logic [31:0] i_address,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [31:0] o_alloc_address,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    t_cmd  w_cmd;
    t_stat w_stat;

    bba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    bba_dp #(
        .MAP_DEPTH (MAP_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_mode          (i_mode),
        .i_size_bytes    (i_size_bytes),
        .i_address       (i_address),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_status        (o_status),
        .o_alloc_address (o_alloc_address)
    );

    a_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_OK) |-> o_alloc_address == 32'd0)
        else $error("address on failed result");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second request taken while busy");

    a_div_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.div_busy |-> o_in_stall)
        else $error("idle while divider runs");
endmodule

// File: test/tb_bitmap_block_allocator_core.sv
`timescale 1ns / 1ps
module tb_bitmap_block_allocator_core;
    import bba_pkg::*;

    localparam int DEPTH = 32;

    typedef struct packed {
        t_mode       mode;
        logic [31:0] size;
        logic [31:0] addr;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic [31:0] addr;
    } t_resp;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_mode = '0;
    logic [31:0] i_size_bytes = '0;
    logic [31:0] i_address = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_status;
    logic [31:0] o_alloc_address;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    bitmap_block_allocator_core #(.MAP_DEPTH(DEPTH)) DUT (.*);

    always #10 i_clk = ~i_clk;

    // predictor state
    logic [31:0] map_q [DEPTH];
    logic [31:0] base_q = 32'd0;
    logic [31:0] region_q = 32'd32768;
    logic [15:0] blk_q = 16'd32;
    logic [5:0]  words_q = 6'd32;

    t_req  pending_q [$];
    t_resp expected_q [$];
    int    errors = 0;
    int    accepted = 0;
    int    total_reqs = 0;
    bit    drive_on = 1'b0;

    function automatic longint unsigned active_blocks();
        longint unsigned w;
        w = words_q;
        if (w > DEPTH) w = DEPTH;
        return w * 32;
    endfunction

    function automatic longint unsigned blocks_for(longint unsigned n);
        longint unsigned b;
        b = (blk_q == 0) ? 1 : blk_q;
        if (n == 0) return 0;
        return (n - 1) / b + 1;
    endfunction

    function automatic void mark_blocks(longint unsigned first, longint unsigned cnt,
                                        bit used);
        longint unsigned last;
        last = first + cnt;
        if (last > active_blocks()) last = active_blocks();
        for (longint unsigned b = first; b < last; b++)
            map_q[b / 32][b % 32] = used;
    endfunction

    function automatic t_resp predict_alloc(t_req r);
        t_resp           res;
        longint unsigned need, run, first, blk;
        bit              found;
        res = '{ST_RANGE, 32'd0};
        run = 0; first = 0; found = 0;
        blk = (blk_q == 0) ? 1 : blk_q;
        case (r.mode)
            MODE_ALLOC: begin
                need = blocks_for(r.size);
                if (need != 0) begin
                    for (longint unsigned b = 0; b < active_blocks() && !found; b++) begin
                        if (map_q[b / 32][b % 32]) begin
                            run = 0;
                        end else begin
                            if (run == 0) first = b;
                            run++;
                            if (run == need) found = 1;
                        end
                    end
                end
                if (found) begin
                    mark_blocks(first, need, 1'b1);
                    res.addr = 32'(longint'(base_q) + first * blk);
                    res.status = ST_OK;
                end else begin
                    res.status = ST_NO_SPACE;
                end
            end
            MODE_FREE: begin
                if (r.addr >= base_q &&
                    longint'(r.addr) < longint'(base_q) + longint'(region_q)) begin
                    mark_blocks(blocks_for(r.addr - base_q), blocks_for(r.size), 1'b0);
                    res.status = ST_OK;
                end
            end
            MODE_INIT: begin
                if (region_q != 0 && r.size <= region_q) begin
                    for (int i = 0; i < DEPTH; i++) map_q[i] = '0;
                    mark_blocks(0, blocks_for(r.size), 1'b1);
                    res.status = ST_OK;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // driver: bursts with random gaps
    int gap_cnt = 0;
    int burst_cnt = 0;
    always @(posedge i_clk) begin
        t_req nx;
        if (i_in_valid && !o_in_stall) begin
            expected_q.push_back(predict_alloc('{t_mode'(i_mode), i_size_bytes, i_address}));
            accepted++;
        end
        if (!i_in_valid || !o_in_stall) begin
            if (drive_on && pending_q.size() != 0 && gap_cnt == 0) begin
                nx = pending_q.pop_front();
                i_in_valid   <= 1'b1;
                i_mode       <= nx.mode;
                i_size_bytes <= nx.size;
                i_address    <= nx.addr;
                if (burst_cnt == 0) begin
                    burst_cnt = $urandom_range(8, 1);
                    gap_cnt = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(40, 1);
                end else begin
                    burst_cnt--;
                end
            end else begin
                i_in_valid <= 1'b0;
                if (gap_cnt != 0) gap_cnt--;
            end
        end
    end

    // receiver stall pattern and monitor
    int stall_mode = 0;
    always @(posedge i_clk) begin
        t_resp want;
        if (o_out_valid && !i_out_stall) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result", 32'(o_status), o_alloc_address);
            end else begin
                want = expected_q.pop_front();
                if (o_status !== want.status)
                    report_mismatch("status", 32'(o_status), 32'(want.status));
                if (o_alloc_address !== want.addr)
                    report_mismatch("alloc_address", o_alloc_address, want.addr);
            end
        end
        if ($urandom_range(200, 0) == 0) stall_mode = $urandom_range(3, 0);
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(3, 0) == 0);
            2: i_out_stall <= ($urandom_range(1, 0) == 0);
            default: i_out_stall <= ($urandom_range(9, 0) != 0);
        endcase
    end

    task automatic write_reg(t_cfg_idx idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_BASE:   base_q = val;
            CFG_REGION: region_q = val;
            CFG_BLOCK:  blk_q = val[15:0];
            default:    words_q = val[5:0];
        endcase
    endtask

    task automatic queue_req(t_mode m, logic [31:0] s, logic [31:0] a);
        pending_q.push_back('{m, s, a});
        total_reqs++;
    endtask

    // run queued requests and drain results before touching the registers
    task automatic run_phase();
        drive_on = 1'b1;
        wait (accepted == total_reqs && expected_q.size() == 0);
        drive_on = 1'b0;
        repeat (20) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_size();
        logic [31:0] bb;
        bb = (blk_q == 0) ? 1 : blk_q;
        case ($urandom_range(9, 0))
            0: return $urandom();
            1: return 32'd0;
            2, 3: return $urandom_range(bb * 4, 1);
            default: return $urandom_range(bb * 40, 1);
        endcase
    endfunction

    function automatic logic [31:0] rand_addr();
        case ($urandom_range(5, 0))
            0: return $urandom();
            1: return base_q + region_q;
            2: return base_q - 1;
            default: return base_q + $urandom_range(region_q == 0 ? 0 : region_q - 1, 0);
        endcase
    endfunction

    task automatic random_phase(int n);
        int k;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(19, 0);
            if (k < 9) queue_req(MODE_ALLOC, rand_size(), $urandom());
            else if (k < 17) queue_req(MODE_FREE, rand_size(), rand_addr());
            else if (k < 19) queue_req(MODE_INIT,
                ($urandom_range(3, 0) == 0) ? $urandom() : $urandom_range(region_q >> 2, 0),
                $urandom());
            else queue_req(MODE_RSVD, $urandom(), $urandom());
        end
        run_phase();
    endtask

    initial begin
        for (int i = 0; i < DEPTH; i++) map_q[i] = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset settings
        queue_req(MODE_ALLOC, 32'd0, 32'd0);
        queue_req(MODE_ALLOC, 32'd1, 32'hffff_ffff);
        queue_req(MODE_ALLOC, 32'd100, 32'd0);
        queue_req(MODE_ALLOC, 32'hffff_ffff, 32'd0);
        queue_req(MODE_FREE, 32'd32, 32'd0);
        queue_req(MODE_FREE, 32'd64, 32'd33);
        queue_req(MODE_FREE, 32'hffff_ffff, 32'd32767);
        queue_req(MODE_FREE, 32'd1, 32'd32768);
        queue_req(MODE_ALLOC, 32'd32, 32'd0);
        queue_req(MODE_INIT, 32'd32769, 32'd0);
        queue_req(MODE_INIT, 32'd32768, 32'd0);
        queue_req(MODE_ALLOC, 32'd1, 32'd0);
        queue_req(MODE_INIT, 32'd0, 32'd0);
        queue_req(MODE_ALLOC, 32'd32768, 32'd0);
        queue_req(MODE_INIT, 32'd33, 32'd0);
        queue_req(MODE_RSVD, 32'hffff_ffff, 32'hffff_ffff);
        run_phase();

        // directed: zero block size, wrapping base, empty map, oversized map
        write_reg(CFG_BLOCK, 32'd0);
        write_reg(CFG_BASE, 32'hffff_fff0);
        write_reg(CFG_REGION, 32'hffff_ffff);
        queue_req(MODE_INIT, 32'd10, 32'd0);
        queue_req(MODE_ALLOC, 32'd40, 32'd0);
        queue_req(MODE_FREE, 32'd5, 32'hffff_fff0);
        queue_req(MODE_FREE, 32'd5, 32'd0);
        run_phase();
        write_reg(CFG_WORDS, 32'd0);
        queue_req(MODE_ALLOC, 32'd1, 32'd0);
        queue_req(MODE_INIT, 32'd100, 32'd0);
        run_phase();
        write_reg(CFG_WORDS, 32'd63);
        write_reg(CFG_REGION, 32'd0);
        queue_req(MODE_INIT, 32'd0, 32'd0);
        queue_req(MODE_ALLOC, 32'd1024, 32'd0);
        run_phase();

        // random phases over several settings
        for (int p = 0; p < 14; p++) begin
            case (p % 5)
                0: begin
                    write_reg(CFG_BASE, $urandom());
                    write_reg(CFG_BLOCK, $urandom_range(64, 1));
                    write_reg(CFG_WORDS, $urandom_range(4, 1));
                    write_reg(CFG_REGION, $urandom_range(8192, 1));
                end
                1: begin
                    write_reg(CFG_BASE, 32'd0);
                    write_reg(CFG_BLOCK, 32'hffff);
                    write_reg(CFG_WORDS, 32'd32);
                    write_reg(CFG_REGION, 32'hffff_ffff);
                end
                2: begin
                    write_reg(CFG_BASE, 32'hffff_ffff);
                    write_reg(CFG_BLOCK, 32'd1);
                    write_reg(CFG_WORDS, $urandom_range(63, 0));
                    write_reg(CFG_REGION, 32'd1);
                end
                3: begin
                    write_reg(CFG_BASE, $urandom());
                    write_reg(CFG_BLOCK, $urandom());
                    write_reg(CFG_WORDS, $urandom());
                    write_reg(CFG_REGION, $urandom());
                end
                default: begin
                    write_reg(CFG_BASE, 32'h1000);
                    write_reg(CFG_BLOCK, 32'd32);
                    write_reg(CFG_WORDS, $urandom_range(8, 1));
                    write_reg(CFG_REGION, 32'd32768);
                end
            endcase
            random_phase(100);
        end

        if (errors == 0) begin
            $display("bitmap_block_allocator_core test passed");
        end else begin
            $display("bitmap_block_allocator_core test failed");
        end
        $finish;
    end

    initial begin
        #200ms;
        $display("bitmap_block_allocator_core test failed");
        $finish;
    end
endmodule
